// ===== hw/rtl/mvgc_pkg.sv =====
// Shared types, constants and log2 tables for the MIDI velocity gamma curve.
package mvgc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned VEL_N      = 1 << VEL_W;
  localparam int unsigned R_W        = 7;
  localparam int unsigned GAMMA_W    = 11;
  localparam int unsigned CHAN_SEL_W = 5;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LOG_FRAC   = 60;
  localparam int unsigned LOG_W      = 63;
  localparam int unsigned PROD_W     = GAMMA_W + LOG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_GAMMA       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_GAMMA      = 2'd2;

  localparam logic [GAMMA_W-1:0]    GAMMA_RESET = 11'd256;
  localparam logic [CHAN_SEL_W-1:0] CHAN_ANY    = 5'd0;
  localparam logic [CHAN_SEL_W-1:0] CHAN_SAT    = 5'd16;
  localparam logic [CHAN_W-1:0]     CHAN_LAST   = 4'd15;

  localparam logic [CHAN_W-1:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [CHAN_W-1:0] TYPE_NOTE_ON  = 4'h9;

  localparam logic [R_W-1:0] VEL_MIN = 7'd1;
  localparam logic [R_W-1:0] VEL_MAX = 7'd127;

  typedef logic [LOG_W-1:0] log_t;
  typedef log_t log_lut_t [VEL_N];

  // Word fields that ride along the pipeline next to the product.
  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic              apply;
    logic              vel_zero;
    logic              gamma_zero;
  } side_t;

  // log2(n) in Q60, truncated, n in 1..255; bit-by-bit squaring of the mantissa.
  function automatic logic [63:0] log2_q60(input int unsigned n);
    int unsigned  e;
    logic [63:0]  m;
    logic [63:0]  res;
    logic [127:0] sq;
    e = 0;
    if (n == 0) return '0;
    for (int unsigned j = 1; j < 8; j++) begin
      if ((n >> j) != 0) e = j;
    end
    m   = 64'(n) << (62 - e);
    res = 64'(e) << LOG_FRAC;
    for (int i = 59; i >= 0; i--) begin
      sq = 128'(m) * 128'(m);
      m  = sq[125:62];
      if (m[63]) begin
        m      = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  // log2(127/v), the distance of v below full scale.
  function automatic log_lut_t build_dist_lut();
    log_lut_t    lut;
    logic [63:0] l127;
    l127 = log2_q60(127);
    for (int unsigned v = 0; v < VEL_N; v++) begin
      lut[v] = LOG_W'(l127 - log2_q60(v));
    end
    return lut;
  endfunction

  // log2(254/(2k+1)), the rounding threshold between k and k+1.
  function automatic log_lut_t build_thr_lut();
    log_lut_t    lut;
    logic [63:0] l127;
    l127 = log2_q60(127);
    for (int unsigned k = 0; k < VEL_N - 1; k++) begin
      lut[k] = LOG_W'(l127 + (64'd1 << LOG_FRAC) - log2_q60(2 * k + 1));
    end
    lut[VEL_N-1] = '0;
    return lut;
  endfunction

  localparam log_lut_t DIST_LUT = build_dist_lut();
  localparam log_lut_t THR_LUT  = build_thr_lut();

endpackage

// ===== hw/rtl/mvgc_front.sv =====
// Message decode, gamma select and gamma times log-distance product stage.
module mvgc_front import mvgc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [BYTE_W-1:0]     status_i,
  input  logic [BYTE_W-1:0]     first_i,
  input  logic [BYTE_W-1:0]     second_i,
  input  logic                  three_i,
  input  logic [CHAN_SEL_W-1:0] channel_select_i,
  input  logic [GAMMA_W-1:0]    on_gamma_i,
  input  logic [GAMMA_W-1:0]    off_gamma_i,
  output logic                  valid_o,
  output logic [PROD_W-1:0]     prod_o,
  output side_t                 side_o
);

  logic [CHAN_W-1:0]  msg_type;
  logic [CHAN_W-1:0]  msg_chan;
  logic [CHAN_W-1:0]  want_chan;
  logic [VEL_W-1:0]   vel;
  logic               is_on;
  logic               is_off;
  logic               match;
  logic [GAMMA_W-1:0] gamma;
  logic               valid_q;
  logic [PROD_W-1:0]  prod_d, prod_q;
  side_t              side_d, side_q;

  assign msg_type = status_i[BYTE_W-1:CHAN_W];
  assign msg_chan = status_i[CHAN_W-1:0];
  assign vel      = second_i[VEL_W-1:0];
  assign is_on    = (msg_type == TYPE_NOTE_ON);
  assign is_off   = (msg_type == TYPE_NOTE_OFF);

  // Selector counts channels from one; saturate past the last channel.
  assign want_chan = (channel_select_i >= CHAN_SAT) ? CHAN_LAST
                   : CHAN_W'(channel_select_i - 1'b1);
  assign match     = (channel_select_i == CHAN_ANY) || (want_chan == msg_chan);
  assign gamma     = is_on ? on_gamma_i : off_gamma_i;

  always_comb begin
    side_d.status     = status_i;
    side_d.first      = first_i;
    side_d.second     = second_i;
    // Note-on at zero velocity is a release: leave it alone.
    side_d.apply      = three_i && match && (is_off || (is_on && (vel != '0)));
    side_d.vel_zero   = (vel == '0);
    side_d.gamma_zero = (gamma == '0);
    prod_d            = PROD_W'(gamma) * PROD_W'(DIST_LUT[vel]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/mvgc_step.sv =====
// One binary-search step over the rounding thresholds: decides one result bit.
module mvgc_step import mvgc_pkg::*; #(
  parameter int BIT       = 6,
  parameter int FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [PROD_W-1:0] prod_i,
  input  logic [R_W-1:0]    r_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [PROD_W-1:0] prod_o,
  output logic [R_W-1:0]    r_o,
  output side_t             side_o
);

  localparam int unsigned    THR_W    = LOG_W + FRAC_BITS;
  localparam int unsigned    CMP_W    = (THR_W > PROD_W) ? THR_W : PROD_W;
  localparam logic [R_W-1:0] STEP_BIT = R_W'(1) << BIT;

  logic [R_W-1:0]    cand;
  logic [R_W-1:0]    idx;
  logic [CMP_W-1:0]  thr;
  logic              pass;
  logic              valid_q;
  logic [PROD_W-1:0] prod_q;
  logic [R_W-1:0]    r_q;
  side_t             side_q;

  // Thresholds fall with k, so the passing ones form a prefix; probe its end.
  assign cand = r_i | STEP_BIT;
  assign idx  = cand - 1'b1;
  assign thr  = CMP_W'(THR_LUT[idx]) << FRAC_BITS;
  assign pass = (CMP_W'(prod_i) <= thr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_i;
    r_q    <= pass ? cand : r_i;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign r_o     = r_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/midi_velocity_gamma_curve_core.sv =====
// Top level of the MIDI velocity gamma curve: config registers, pipeline and result register.
//
// One MIDI word enters on every clock edge with start high (busy is always low), and
// its result word leaves from the result register at the end of the path below: strobe_o is high for exactly one
// cycle and the result is taken at the edge that ends it; the receiver cannot stall,
// so nothing is held back and words leave in the order they came. A three-byte
// note-on or note-off on the selected channel gets its velocity v replaced by
// round(127*(v/127)^gamma), clamped to 1..127; a note-on of velocity zero passes
// unchanged. The path is one register per step: input register, a decode stage that
// multiplies the 11-bit gamma by a Q60 log2 distance from a 128-entry table, seven
// binary-search stages that each compare that product with one rounding threshold
// from a second table, and the result register. The rate is one word per cycle,
// since every stage takes a new word on each edge and nothing ever stalls; the widest
// stage, the 11 x 63 bit multiply or the 74-bit compare, sets the clock period.
// Configuration writes take effect at once; write them only when no word is in flight.
module midi_velocity_gamma_curve_core import mvgc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAMMA_W-1:0]   cfg_data_i,
  input  logic [BYTE_W-1:0]    status_byte_i,
  input  logic [BYTE_W-1:0]    first_data_i,
  input  logic [BYTE_W-1:0]    second_data_i,
  input  logic                 three_byte_message_i,
  output logic                 strobe_o,
  output logic [BYTE_W-1:0]    out_status_o,
  output logic [BYTE_W-1:0]    out_first_o,
  output logic [BYTE_W-1:0]    out_second_o,
  output logic                 was_changed_o
);

  logic [CHAN_SEL_W-1:0] channel_select_q;
  logic [GAMMA_W-1:0]    on_gamma_q;
  logic [GAMMA_W-1:0]    off_gamma_q;

  logic                  in_valid_q;
  logic [BYTE_W-1:0]     in_status_q;
  logic [BYTE_W-1:0]     in_first_q;
  logic [BYTE_W-1:0]     in_second_q;
  logic                  in_three_q;
  logic                  accept;

  logic                  st_valid [R_W+1];
  logic [PROD_W-1:0]     st_prod  [R_W+1];
  logic [R_W-1:0]        st_r     [R_W+1];
  side_t                 st_side  [R_W+1];

  logic [R_W-1:0]        curve_vel;
  logic [BYTE_W-1:0]     second_d;
  logic                  strobe_q;
  logic [BYTE_W-1:0]     out_status_q;
  logic [BYTE_W-1:0]     out_first_q;
  logic [BYTE_W-1:0]     out_second_q;
  logic                  was_changed_q;

  // The pipeline takes a word every cycle, so never report busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Config registers; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_select_q <= CHAN_ANY;
      on_gamma_q       <= GAMMA_RESET;
      off_gamma_q      <= GAMMA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNEL_SELECT: channel_select_q <= cfg_data_i[CHAN_SEL_W-1:0];
        CFG_ON_GAMMA:       on_gamma_q       <= cfg_data_i;
        CFG_OFF_GAMMA:      off_gamma_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: capture the word on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_status_q <= status_byte_i;
      in_first_q  <= first_data_i;
      in_second_q <= second_data_i;
      in_three_q  <= three_byte_message_i;
    end
  end

  // Decode and multiply: gamma * log2(127/v).
  mvgc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_q),
    .status_i         (in_status_q),
    .first_i          (in_first_q),
    .second_i         (in_second_q),
    .three_i          (in_three_q),
    .channel_select_i (channel_select_q),
    .on_gamma_i       (on_gamma_q),
    .off_gamma_i      (off_gamma_q),
    .valid_o          (st_valid[0]),
    .prod_o           (st_prod[0]),
    .side_o           (st_side[0])
  );

  // Count the thresholds the product stays under, most significant bit first.
  assign st_r[0] = '0;

  for (genvar s = 0; s < R_W; s++) begin : g_step
    mvgc_step #(
      .BIT       (R_W - 1 - s),
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[s]),
      .prod_i  (st_prod[s]),
      .r_i     (st_r[s]),
      .side_i  (st_side[s]),
      .valid_o (st_valid[s+1]),
      .prod_o  (st_prod[s+1]),
      .r_o     (st_r[s+1]),
      .side_o  (st_side[s+1])
    );
  end

  // Clamp the count to 1..127; zero velocity note-off maps to 127 at gamma zero, else 1.
  always_comb begin
    curve_vel = (st_r[R_W] == '0) ? VEL_MIN : st_r[R_W];
    if (st_side[R_W].vel_zero) begin
      curve_vel = st_side[R_W].gamma_zero ? VEL_MAX : VEL_MIN;
    end
    second_d = st_side[R_W].apply ? BYTE_W'(curve_vel) : st_side[R_W].second;
  end

  // Result register: one strobe per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= st_valid[R_W];
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= st_side[R_W].status;
    out_first_q   <= st_side[R_W].first;
    out_second_q  <= second_d;
    was_changed_q <= st_side[R_W].apply;
  end

  assign strobe_o      = strobe_q;
  assign out_status_o  = out_status_q;
  assign out_first_o   = out_first_q;
  assign out_second_o  = out_second_q;
  assign was_changed_o = was_changed_q;

endmodule
